// ----- hdl/drg_pkg.sv -----
package drg_pkg;

    localparam int ENTRIES = 4;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ADDR_W  = 32;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef t_addr             t_addr_arr [ENTRIES];

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERLAP   = 2'd1,
        ST_BAD_INDEX = 2'd2
    } t_status;

    typedef enum logic {
        FN_WRITE = 1'b0,
        FN_CHECK = 1'b1
    } t_func;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_addr            base;
        t_addr            size;
    } t_tbl_wr;

endpackage

// ----- hdl/drg_table.sv -----
module drg_table
    import drg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_tbl_wr            i_wr,
    output t_addr_arr          o_base,
    output t_addr_arr          o_size,
    output logic [ENTRIES-1:0] o_active
);

    t_addr_arr          r_base;
    t_addr_arr          r_size;
    logic [ENTRIES-1:0] r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_wr.en) begin
            r_active[i_wr.idx] <= (i_wr.size != '0);
        end
    end

    // base and size are only looked at while the entry is active
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_base[i_wr.idx] <= i_wr.base;
            r_size[i_wr.idx] <= i_wr.size;
        end
    end

    assign o_base   = r_base;
    assign o_size   = r_size;
    assign o_active = r_active;

endmodule

// ----- hdl/drg_check.sv -----
module drg_check
    import drg_pkg::*;
(
    input  t_addr_arr          i_base,
    input  t_addr_arr          i_size,
    input  logic [ENTRIES-1:0] i_active,
    input  t_addr              i_address,
    input  t_addr              i_length,
    output logic               o_overlap
);

    t_addr              xfer_end;
    logic [ENTRIES-1:0] hit;

    assign xfer_end = i_address + i_length;

    // one compare pair per entry, all in parallel; sums wrap at 32 bits
    always_comb begin
        for (int k = 0; k < ENTRIES; k++) begin
            hit[k] = i_active[k]
                     && (i_address < t_addr'(i_base[k] + i_size[k]))
                     && (xfer_end > i_base[k]);
        end
    end

    assign o_overlap = |hit;

endmodule

// ----- hdl/dma_target_range_guard.sv -----
// result path: the input register, then the result register, loaded once the output register is free
// throughput: one word per cycle while the output is not stalled; the table write and the range compare
// both happen in the stage between the two registers, so a check sees a write just ahead of it
// reset: synchronous active-low i_rst_n empties both registers and marks every entry inactive
module dma_target_range_guard
    import drg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // entry_index[7:0], address[39:8], length[71:40]
    input  logic        i_s_axis_tuser,  // func[0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata   // status[1:0], zero above
);

    logic       r_in_valid;
    t_func      r_func;
    logic [7:0] r_idx;
    t_addr      r_address;
    t_addr      r_length;

    logic       r_out_valid;
    t_status    r_status;

    logic               advance;
    logic               bad_idx;
    logic               overlap;
    t_status            n_status;
    t_tbl_wr            tbl_wr;
    t_addr_arr          tbl_base;
    t_addr_arr          tbl_size;
    logic [ENTRIES-1:0] tbl_active;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_func    <= t_func'(i_s_axis_tuser);
            r_idx     <= i_s_axis_tdata[7:0];
            r_address <= i_s_axis_tdata[39:8];
            r_length  <= i_s_axis_tdata[71:40];
        end
    end

    assign bad_idx = (r_idx >= 8'(ENTRIES));

    always_comb begin
        tbl_wr.en   = advance && (r_func == FN_WRITE) && !bad_idx;
        tbl_wr.idx  = r_idx[IDX_W-1:0];
        tbl_wr.base = r_address;
        tbl_wr.size = r_length;
    end

    drg_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (tbl_wr),
        .o_base   (tbl_base),
        .o_size   (tbl_size),
        .o_active (tbl_active)
    );

    drg_check u_check (
        .i_base    (tbl_base),
        .i_size    (tbl_size),
        .i_active  (tbl_active),
        .i_address (r_address),
        .i_length  (r_length),
        .o_overlap (overlap)
    );

    always_comb begin
        case (r_func)
            FN_WRITE: n_status = bad_idx ? ST_BAD_INDEX : ST_OK;
            FN_CHECK: n_status = overlap ? ST_OVERLAP : ST_OK;
            default:  n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_status <= n_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_status};

endmodule
